// File: sv/vtpd_pkg.sv
package vtpd_pkg;
	localparam int unsigned PairCount = 8;
	localparam int unsigned FracBits = 16;
	localparam int unsigned IdxW = 3;
	localparam int unsigned AccW = 66;
	// magnitude of a row sum before the divide
	localparam int unsigned MagW = 50;
	// numerator magnitude shifted up by the fraction bits
	localparam int unsigned NumW = MagW + FracBits;
	// quotient bits kept; anything above bit 32 only saturates
	localparam int unsigned QW = 33;
	localparam logic [63:0] ResetPair0 = 64'h0000_0000_0001_0000;
	localparam logic [63:0] ResetPair2 = 64'h0001_0000_0000_0000;

	typedef struct packed {
		logic        neg;
		logic [QW:0] q;
	} quot_t;
endpackage

// File: sv/vertex_transform_perspective_divide_unit.sv
// pipeline: 2 multiply/sum stages, 1 magnitude stage, 66 divider stages and
// 1 saturating output register
// throughput: one word per cycle; a stall freezes the whole pipeline
// the divider holds one stage per quotient bit, which sets the depth
// reset: valid bits cleared, matrix returns to identity
module vertex_transform_perspective_divide_unit
	import vtpd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic               w_zero,
	input  logic               cfg_we,
	input  logic [63:0]        cfg_index,
	input  logic [63:0]        cfg_data
);
	localparam int unsigned Depth = 4 + NumW;

	logic [63:0] pair_q [0:PairCount-1];
	logic [Depth-1:0] vld_q;
	logic en;

	// pipeline advances when the last stage is empty or is being taken
	assign en = !out_valid || !out_stall;
	assign in_stall = !en;

	// matrix registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PairCount; k++) begin
				if (k inside {0, 5}) begin
					pair_q[k] <= ResetPair0;
				end else if (k inside {2, 7}) begin
					pair_q[k] <= ResetPair2;
				end else begin
					pair_q[k] <= '0;
				end
			end
		end else if (cfg_we && cfg_index < 64'(PairCount)) begin
			pair_q[cfg_index[IdxW-1:0]] <= cfg_data;
		end
	end

	// valid bits travel along with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[Depth-2:0], in_valid};
		end
	end
	assign out_valid = vld_q[Depth-1];

	function automatic logic signed [31:0] el(input int unsigned k, input logic [63:0] p);
		return (k % 2 == 1) ? p[63:32] : p[31:0];
	endfunction

	// stage 1: twelve exact products plus the translation column
	logic signed [63:0] prod_s1 [0:3][0:2];
	logic signed [31:0] tr_s1   [0:3];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 4; j++) begin
				prod_s1[j][0] <= point_x * el(4*j,   pair_q[2*j]);
				prod_s1[j][1] <= point_y * el(4*j+1, pair_q[2*j]);
				prod_s1[j][2] <= point_z * el(4*j+2, pair_q[2*j+1]);
				tr_s1[j]      <= el(4*j+3, pair_q[2*j+1]);
			end
		end
	end

	// stage 2: row sums; the translation times one is exact at bit 16
	logic signed [AccW-1:0] u_s2 [0:3];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 4; j++) begin
				u_s2[j] <= AccW'(prod_s1[j][0]) + AccW'(prod_s1[j][1])
					+ AccW'(prod_s1[j][2]) + (AccW'(tr_s1[j]) <<< FracBits);
			end
		end
	end

	// stage 3: shift, magnitudes and signs; the quotient sign follows u_j and w
	logic [MagW-1:0] nm_s3 [0:2];
	logic [MagW-1:0] dm_s3;
	logic            ng_s3 [0:2];
	logic            wz_s3;
	logic signed [AccW-FracBits-1:0] sh [0:3];
	logic [AccW-FracBits-1:0] mg [0:3];
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			sh[j] = u_s2[j][AccW-1:FracBits];
			mg[j] = sh[j][AccW-FracBits-1] ? -sh[j] : sh[j];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				nm_s3[j] <= mg[j][MagW-1:0];
				ng_s3[j] <= sh[j][AccW-FracBits-1] ^ sh[3][AccW-FracBits-1];
			end
			dm_s3 <= mg[3][MagW-1:0];
			wz_s3 <= (sh[3] == '0);
		end
	end

	// divider lanes; zero w is carried alongside
	quot_t res [0:2];
	for (genvar j = 0; j < 3; j++) begin : g_div
		vtpd_div u_div (
			.clk (clk),
			.en  (en),
			.num ({nm_s3[j], {FracBits{1'b0}}}),
			.den ((dm_s3 == '0) ? MagW'(1) : dm_s3),
			.neg (ng_s3[j]),
			.res (res[j])
		);
	end
	logic [NumW-1:0] wz_dly_q;
	always_ff @(posedge clk) begin
		if (en) begin
			wz_dly_q <= {wz_dly_q[NumW-2:0], wz_s3};
		end
	end

	// saturation into the Q16.16 range (zero when w is zero), then the output register
	logic [31:0] sat [0:2];
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			if (wz_dly_q[NumW-1]) begin
				sat[j] = '0;
			end else if (res[j].neg) begin
				sat[j] = (res[j].q >= (QW+1)'(33'h0_8000_0000)) ? 32'h8000_0000
					: 32'(-res[j].q);
			end else begin
				sat[j] = (res[j].q > (QW+1)'(33'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF
					: res[j].q[31:0];
			end
		end
	end
	logic [31:0] ox_s4, oy_s4, oz_s4;
	logic        wz_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			ox_s4 <= sat[0];
			oy_s4 <= sat[1];
			oz_s4 <= sat[2];
			wz_s4 <= wz_dly_q[NumW-1];
		end
	end
	assign out_x  = ox_s4;
	assign out_y  = oy_s4;
	assign out_z  = oz_s4;
	assign w_zero = wz_s4;
endmodule

// File: sv/vtpd_div.sv
// pipelined restoring divider, one quotient bit per stage
module vtpd_div
	import vtpd_pkg::*;
(
	input  logic            clk,
	input  logic            en,
	input  logic [NumW-1:0] num,
	input  logic [MagW-1:0] den,
	input  logic            neg,
	output quot_t           res
);
	localparam int unsigned Steps = NumW;
	logic [MagW:0]   rem_s [0:Steps];
	logic [NumW-1:0] sh_s  [0:Steps];
	logic [MagW-1:0] den_s [0:Steps];
	logic [QW:0]     q_s   [0:Steps];
	logic            neg_s [0:Steps];

	always_comb begin
		rem_s[0] = '0;
		sh_s[0]  = num;
		den_s[0] = den;
		q_s[0]   = '0;
		neg_s[0] = neg;
	end

	for (genvar k = 0; k < Steps; k++) begin : g_step
		logic [MagW+1:0] trial;
		logic [MagW+1:0] diff;
		always_comb begin
			trial = {rem_s[k], sh_s[k][NumW-1]};
			diff  = trial - {2'b00, den_s[k]};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sh_s[k+1]  <= {sh_s[k][NumW-2:0], 1'b0};
				den_s[k+1] <= den_s[k];
				neg_s[k+1] <= neg_s[k];
				if (!diff[MagW+1]) begin
					rem_s[k+1] <= diff[MagW:0];
					q_s[k+1]   <= (q_s[k][QW] ? q_s[k] : {q_s[k][QW-1:0], 1'b1});
				end else begin
					rem_s[k+1] <= trial[MagW:0];
					q_s[k+1]   <= (q_s[k][QW] ? q_s[k] : {q_s[k][QW-1:0], 1'b0});
				end
			end
		end
	end

	assign res.q   = q_s[Steps];
	assign res.neg = neg_s[Steps];
endmodule

// File: sv/vtpd_checker.sv
module vtpd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] out_x,
	input logic [31:0] out_y,
	input logic [31:0] out_z,
	input logic        w_zero
);
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && w_zero |-> out_x == 0 && out_y == 0 && out_z == 0)
		else $error("nonzero word with zero w");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output stall");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_x))
		else $error("stalled word changed");
endmodule

bind vertex_transform_perspective_divide_unit vtpd_checker u_chk (.*);
